### design/chunk_grid_summed_area_table_defines.svh
// assertion macros used by the summed-area table top level
`ifndef CHUNK_GRID_SUMMED_AREA_TABLE_DEFINES_SVH
`define CHUNK_GRID_SUMMED_AREA_TABLE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CGSAT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cgsat same-cycle check failed");

// next-cycle implication, disabled during reset
`define CGSAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cgsat next-cycle check failed");

`endif

### design/cgsat_pkg.sv
// package with types and constants of the summed-area table
package cgsat_pkg;

  localparam int FIELD_W   = 48;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CMP_W     = 9;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_COMPUTE = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_PLANES = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_COMPUTE
  } top_state_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_ROW,
    SQ_GAP,
    SQ_COL,
    SQ_DRAIN
  } seq_state_t;

  typedef struct packed {
    logic rd_en;
    logic load_en;
    logic acc_load;
    logic acc_add;
  } lane_ctl_t;

endpackage

### design/cgsat_ram.sv
// generic simple dual-port ram with registered read
module cgsat_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/cgsat_lane.sv
// one color lane: count store plus running-sum accumulator
module cgsat_lane #(
  parameter int SUM_WIDTH = 48,
  parameter int AW        = 10
) (
  input  logic                  clk,
  input  cgsat_pkg::lane_ctl_t  ctl,
  input  logic [AW-1:0]         rd_addr,
  input  logic [AW-1:0]         wr_addr,
  input  logic [SUM_WIDTH-1:0]  load_data,
  output logic [SUM_WIDTH-1:0]  rd_data
);

  logic [SUM_WIDTH-1:0] acc;
  logic [SUM_WIDTH-1:0] sum;
  logic [SUM_WIDTH-1:0] wr_data;
  logic                 wr_en;

  assign sum     = rd_data + acc;
  assign wr_en   = ctl.load_en | ctl.acc_add;
  assign wr_data = ctl.load_en ? load_data : sum;

  always_ff @(posedge clk) begin
    if (ctl.acc_load) begin
      acc <= rd_data;
    end else if (ctl.acc_add) begin
      acc <= sum;
    end
  end

  cgsat_ram #(
    .WIDTH (SUM_WIDTH),
    .DEPTH (2 ** AW)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (ctl.rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

endmodule

### design/cgsat_seq.sv
// address sequencer for the row and column prefix-sum passes
module cgsat_seq #(
  parameter int MAX_GRID_X = 16,
  parameter int MAX_GRID_Y = 16,
  parameter int MAX_GRID_Z = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [$clog2(MAX_GRID_X+1)-1:0]     gw,
  input  logic [$clog2(MAX_GRID_Y+1)-1:0]     gh,
  input  logic [$clog2(MAX_GRID_Z+1)-1:0]     gp,
  output cgsat_pkg::lane_ctl_t                ctl,
  output logic [((MAX_GRID_X > 1) ? $clog2(MAX_GRID_X) : 1)
               + ((MAX_GRID_Y > 1) ? $clog2(MAX_GRID_Y) : 1)
               + ((MAX_GRID_Z > 1) ? $clog2(MAX_GRID_Z) : 1) - 1:0] rd_addr,
  output logic [((MAX_GRID_X > 1) ? $clog2(MAX_GRID_X) : 1)
               + ((MAX_GRID_Y > 1) ? $clog2(MAX_GRID_Y) : 1)
               + ((MAX_GRID_Z > 1) ? $clog2(MAX_GRID_Z) : 1) - 1:0] wr_addr,
  output logic                                done
);

  localparam int XW  = (MAX_GRID_X > 1) ? $clog2(MAX_GRID_X) : 1;
  localparam int YW  = (MAX_GRID_Y > 1) ? $clog2(MAX_GRID_Y) : 1;
  localparam int ZW  = (MAX_GRID_Z > 1) ? $clog2(MAX_GRID_Z) : 1;
  localparam int AW  = XW + YW + ZW;
  localparam int GXW = $clog2(MAX_GRID_X + 1);
  localparam int GYW = $clog2(MAX_GRID_Y + 1);
  localparam int GZW = $clog2(MAX_GRID_Z + 1);

  cgsat_pkg::seq_state_t state, state_next;

  logic [XW-1:0] cx, cx_next;
  logic [YW-1:0] cy, cy_next;
  logic [ZW-1:0] cz, cz_next;

  logic          s1_valid;
  logic          s1_first;
  logic [AW-1:0] s1_addr;

  logic x_last, y_last, z_last;
  logic first;

  assign x_last = (GXW'(cx) + GXW'(1)) == gw;
  assign y_last = (GYW'(cy) + GYW'(1)) == gh;
  assign z_last = (GZW'(cz) + GZW'(1)) == gp;

  // next state and counters
  always_comb begin
    state_next = state;
    cx_next    = cx;
    cy_next    = cy;
    cz_next    = cz;
    case (state)
      cgsat_pkg::SQ_IDLE: begin
        cx_next = '0;
        cy_next = '0;
        cz_next = '0;
        if (start) begin
          state_next = cgsat_pkg::SQ_ROW;
        end
      end
      cgsat_pkg::SQ_ROW: begin
        if (!x_last) begin
          cx_next = cx + XW'(1);
        end else begin
          cx_next = '0;
          if (!y_last) begin
            cy_next = cy + YW'(1);
          end else begin
            cy_next = '0;
            if (!z_last) begin
              cz_next = cz + ZW'(1);
            end else begin
              cz_next    = '0;
              state_next = cgsat_pkg::SQ_GAP;
            end
          end
        end
      end
      cgsat_pkg::SQ_GAP: begin
        state_next = cgsat_pkg::SQ_COL;
      end
      cgsat_pkg::SQ_COL: begin
        if (!y_last) begin
          cy_next = cy + YW'(1);
        end else begin
          cy_next = '0;
          if (!x_last) begin
            cx_next = cx + XW'(1);
          end else begin
            cx_next = '0;
            if (!z_last) begin
              cz_next = cz + ZW'(1);
            end else begin
              cz_next    = '0;
              state_next = cgsat_pkg::SQ_DRAIN;
            end
          end
        end
      end
      cgsat_pkg::SQ_DRAIN: begin
        state_next = cgsat_pkg::SQ_IDLE;
      end
      default: begin
        state_next = cgsat_pkg::SQ_IDLE;
      end
    endcase
  end

  // read issue and pass-end flag
  always_comb begin
    ctl.rd_en = 1'b0;
    first     = 1'b0;
    done      = 1'b0;
    case (state)
      cgsat_pkg::SQ_ROW: begin
        ctl.rd_en = 1'b1;
        first     = (cx == '0);
      end
      cgsat_pkg::SQ_COL: begin
        ctl.rd_en = 1'b1;
        first     = (cy == '0);
      end
      cgsat_pkg::SQ_DRAIN: begin
        done = 1'b1;
      end
      default: begin
        ctl.rd_en = 1'b0;
      end
    endcase
    ctl.load_en  = 1'b0;
    ctl.acc_load = s1_valid & s1_first;
    ctl.acc_add  = s1_valid & ~s1_first;
  end

  assign rd_addr = {cz, cy, cx};
  assign wr_addr = s1_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= cgsat_pkg::SQ_IDLE;
      cx       <= '0;
      cy       <= '0;
      cz       <= '0;
      s1_valid <= 1'b0;
    end else begin
      state    <= state_next;
      cx       <= cx_next;
      cy       <= cy_next;
      cz       <= cz_next;
      s1_valid <= ctl.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= first;
    s1_addr  <= rd_addr;
  end

endmodule

### design/chunk_grid_summed_area_table.sv
// top level: chunk-grid summed-area table with three color lanes
//
// input channel: in_valid / in_stall with command, chunk coordinate and a
// blue, green, red count triplet. a load writes the triplet, a read returns
// the stored triplet, a compute turns every configured plane into an
// inclusive 2-d prefix sum (rows first, then columns).
// output channel: out_valid / out_stall, exactly one result per transfer
// in: status (1 = coordinate outside the grid) and the summed triplet on a
// read, zero otherwise.
// config port: cfg_we, cfg_index, cfg_data; grid width, height and planes,
// clamped to 1..max on write (planes from the low three bits of cfg_data).
// path: a load or unused command passes the holding and output registers
// to out_valid, an in-range read first passes the registered lane memory read; a compute
// runs one pipelined read, add and write per cell and pass on the dual-port lane memories.
// one item is worked at a time; a finished result waits in a holding register
// while the output register is stalled, so one more item can be taken and
// completed; in_stall is high from each accept until its result moves on.
// reset (rst, synchronous) empties the output path and sets the grid to
// 1x1x1; store contents are undefined until loaded.
`include "chunk_grid_summed_area_table_defines.svh"

module chunk_grid_summed_area_table #(
  parameter int MAX_GRID_X = 16,
  parameter int MAX_GRID_Y = 16,
  parameter int MAX_GRID_Z = 4,
  parameter int SUM_WIDTH  = 48
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [cgsat_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cgsat_pkg::CFG_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          command,
  input  logic [3:0]                          chunk_x,
  input  logic [3:0]                          chunk_y,
  input  logic [1:0]                          chunk_z,
  input  logic [cgsat_pkg::FIELD_W-1:0]       blue_in,
  input  logic [cgsat_pkg::FIELD_W-1:0]       green_in,
  input  logic [cgsat_pkg::FIELD_W-1:0]       red_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                status,
  output logic [cgsat_pkg::FIELD_W-1:0]       blue_sum,
  output logic [cgsat_pkg::FIELD_W-1:0]       green_sum,
  output logic [cgsat_pkg::FIELD_W-1:0]       red_sum
);

  localparam int XW  = (MAX_GRID_X > 1) ? $clog2(MAX_GRID_X) : 1;
  localparam int YW  = (MAX_GRID_Y > 1) ? $clog2(MAX_GRID_Y) : 1;
  localparam int ZW  = (MAX_GRID_Z > 1) ? $clog2(MAX_GRID_Z) : 1;
  localparam int AW  = XW + YW + ZW;
  localparam int GXW = $clog2(MAX_GRID_X + 1);
  localparam int GYW = $clog2(MAX_GRID_Y + 1);
  localparam int GZW = $clog2(MAX_GRID_Z + 1);
  localparam int FW  = cgsat_pkg::FIELD_W;
  localparam int CW  = cgsat_pkg::CMP_W;

  logic [GXW-1:0] gw;
  logic [GYW-1:0] gh;
  logic [GZW-1:0] gp;

  cgsat_pkg::top_state_t state, state_next;

  logic          accept;
  logic          in_range;
  logic [AW-1:0] in_addr;

  cgsat_pkg::lane_ctl_t ctl;
  cgsat_pkg::lane_ctl_t seq_ctl;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        seq_rd_addr;
  logic [AW-1:0]        seq_wr_addr;
  logic                 seq_start;
  logic                 seq_done;

  logic [SUM_WIDTH-1:0] blue_rd;
  logic [SUM_WIDTH-1:0] green_rd;
  logic [SUM_WIDTH-1:0] red_rd;

  logic          res_set;
  logic          res_take;
  logic          res_status_next;
  logic          res_valid;
  logic          res_status;
  logic [FW-1:0] res_blue;
  logic [FW-1:0] res_green;
  logic [FW-1:0] res_red;
  logic          res_move;

  logic [CW-1:0] cfg_v;

  // configuration with clamping to 1..max
  assign cfg_v = CW'(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      gw <= GXW'(1);
      gh <= GYW'(1);
      gp <= GZW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        cgsat_pkg::REG_GRID_WIDTH: begin
          if (cfg_v == '0) begin
            gw <= GXW'(1);
          end else if (cfg_v > CW'(MAX_GRID_X)) begin
            gw <= GXW'(MAX_GRID_X);
          end else begin
            gw <= GXW'(cfg_v);
          end
        end
        cgsat_pkg::REG_GRID_HEIGHT: begin
          if (cfg_v == '0) begin
            gh <= GYW'(1);
          end else if (cfg_v > CW'(MAX_GRID_Y)) begin
            gh <= GYW'(MAX_GRID_Y);
          end else begin
            gh <= GYW'(cfg_v);
          end
        end
        cgsat_pkg::REG_GRID_PLANES: begin
          if (cfg_v[2:0] == '0) begin
            gp <= GZW'(1);
          end else if (CW'(cfg_v[2:0]) > CW'(MAX_GRID_Z)) begin
            gp <= GZW'(MAX_GRID_Z);
          end else begin
            gp <= GZW'(cfg_v[2:0]);
          end
        end
        default: begin
          gw <= gw;
        end
      endcase
    end
  end

  // input side
  assign in_stall = (state != cgsat_pkg::ST_IDLE) | res_valid;
  assign accept   = in_valid & ~in_stall;
  assign in_range = (CW'(chunk_x) < CW'(gw)) & (CW'(chunk_y) < CW'(gh))
                  & (CW'(chunk_z) < CW'(gp));
  assign in_addr  = {ZW'(chunk_z), YW'(chunk_y), XW'(chunk_x)};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cgsat_pkg::ST_IDLE: begin
        if (accept && command == cgsat_pkg::CMD_READ && in_range) begin
          state_next = cgsat_pkg::ST_READ;
        end else if (accept && command == cgsat_pkg::CMD_COMPUTE) begin
          state_next = cgsat_pkg::ST_COMPUTE;
        end
      end
      cgsat_pkg::ST_READ: begin
        state_next = cgsat_pkg::ST_IDLE;
      end
      cgsat_pkg::ST_COMPUTE: begin
        if (seq_done) begin
          state_next = cgsat_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cgsat_pkg::ST_IDLE;
      end
    endcase
  end

  // lane control and result capture
  always_comb begin
    ctl             = '0;
    rd_addr         = in_addr;
    wr_addr         = in_addr;
    seq_start       = 1'b0;
    res_set         = 1'b0;
    res_take        = 1'b0;
    res_status_next = 1'b0;
    case (state)
      cgsat_pkg::ST_IDLE: begin
        if (accept) begin
          case (command)
            cgsat_pkg::CMD_LOAD: begin
              ctl.load_en     = in_range;
              res_set         = 1'b1;
              res_status_next = ~in_range;
            end
            cgsat_pkg::CMD_READ: begin
              ctl.rd_en       = in_range;
              res_set         = ~in_range;
              res_status_next = ~in_range;
            end
            cgsat_pkg::CMD_COMPUTE: begin
              seq_start = 1'b1;
            end
            default: begin
              res_set = 1'b1;
            end
          endcase
        end
      end
      cgsat_pkg::ST_READ: begin
        res_set  = 1'b1;
        res_take = 1'b1;
      end
      cgsat_pkg::ST_COMPUTE: begin
        ctl     = seq_ctl;
        rd_addr = seq_rd_addr;
        wr_addr = seq_wr_addr;
        res_set = seq_done;
      end
      default: begin
        res_set = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cgsat_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  cgsat_seq #(
    .MAX_GRID_X (MAX_GRID_X),
    .MAX_GRID_Y (MAX_GRID_Y),
    .MAX_GRID_Z (MAX_GRID_Z)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (seq_start),
    .gw      (gw),
    .gh      (gh),
    .gp      (gp),
    .ctl     (seq_ctl),
    .rd_addr (seq_rd_addr),
    .wr_addr (seq_wr_addr),
    .done    (seq_done)
  );

  cgsat_lane #(
    .SUM_WIDTH (SUM_WIDTH),
    .AW        (AW)
  ) u_lane_blue (
    .clk       (clk),
    .ctl       (ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .load_data (SUM_WIDTH'(blue_in)),
    .rd_data   (blue_rd)
  );

  cgsat_lane #(
    .SUM_WIDTH (SUM_WIDTH),
    .AW        (AW)
  ) u_lane_green (
    .clk       (clk),
    .ctl       (ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .load_data (SUM_WIDTH'(green_in)),
    .rd_data   (green_rd)
  );

  cgsat_lane #(
    .SUM_WIDTH (SUM_WIDTH),
    .AW        (AW)
  ) u_lane_red (
    .clk       (clk),
    .ctl       (ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .load_data (SUM_WIDTH'(red_in)),
    .rd_data   (red_rd)
  );

  // merge lanes into the holding register, then into the output register
  assign res_move = res_valid & (~out_valid | ~out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (res_set) begin
        res_valid <= 1'b1;
      end else if (res_move) begin
        res_valid <= 1'b0;
      end
      if (res_move) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_set) begin
      res_status <= res_status_next;
      res_blue   <= res_take ? FW'(blue_rd) : '0;
      res_green  <= res_take ? FW'(green_rd) : '0;
      res_red    <= res_take ? FW'(red_rd) : '0;
    end
    if (res_move) begin
      status    <= res_status;
      blue_sum  <= res_blue;
      green_sum <= res_green;
      red_sum   <= res_red;
    end
  end

  `CGSAT_ASSERT_IMPL(a_done_in_compute, clk, rst, seq_done, state == cgsat_pkg::ST_COMPUTE)
  `CGSAT_ASSERT_NEXT(a_accept_leaves_work, clk, rst, accept, in_stall)
  `CGSAT_ASSERT_IMPL(a_out_from_hold, clk, rst, $rose(out_valid), $past(res_valid))

endmodule

### sim/tb_chunk_grid_summed_area_table.sv
`timescale 1ns / 1ps
// self-checking testbench for the chunk-grid summed-area table with its own prefix-sum predictor
module tb_chunk_grid_summed_area_table;

  localparam int GRID_X = 16;
  localparam int GRID_Y = 16;
  localparam int GRID_Z = 4;
  localparam int CELL_COUNT = GRID_X * GRID_Y * GRID_Z;
  localparam int SWEEP_LIMIT = 256;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int TARGET_ITEMS = 1700;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_OUT_OF_GRID = 1'b1;

  typedef logic [cgsat_pkg::FIELD_W-1:0] count_t;
  localparam count_t ALL_ONES = '1;

  typedef struct {
    logic   status;
    count_t blue;
    count_t green;
    count_t red;
  } sum_result_t;

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [cgsat_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cgsat_pkg::CFG_W-1:0]     cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic [1:0]                      command;
  logic [3:0]                      chunk_x;
  logic [3:0]                      chunk_y;
  logic [1:0]                      chunk_z;
  count_t                          blue_in;
  count_t                          green_in;
  count_t                          red_in;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic                            status;
  count_t                          blue_sum;
  count_t                          green_sum;
  count_t                          red_sum;

  count_t blue_cells [CELL_COUNT];
  count_t green_cells [CELL_COUNT];
  count_t red_cells [CELL_COUNT];
  bit     loaded_cells [CELL_COUNT];
  int     grid_w = 1;
  int     grid_h = 1;
  int     grid_p = 1;

  sum_result_t expected_sums [$];
  int items_sent = 0;
  int mismatches = 0;
  bit calm = 1'b0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;

  chunk_grid_summed_area_table uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .chunk_x(chunk_x),
    .chunk_y(chunk_y),
    .chunk_z(chunk_z),
    .blue_in(blue_in),
    .green_in(green_in),
    .red_in(red_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .blue_sum(blue_sum),
    .green_sum(green_sum),
    .red_sum(red_sum)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int clamp_dim(int value, int limit);
    if (value < 1) return 1;
    if (value > limit) return limit;
    return value;
  endfunction

  function automatic int cell_of(int x, int y, int z);
    return (z * GRID_Y + y) * GRID_X + x;
  endfunction

  function automatic void add_cell(int dst, int src);
    blue_cells[dst] = blue_cells[dst] + blue_cells[src];
    green_cells[dst] = green_cells[dst] + green_cells[src];
    red_cells[dst] = red_cells[dst] + red_cells[src];
  endfunction

  // rows first, then columns, in place
  function automatic void sum_planes();
    for (int z = 0; z < grid_p; z++)
      for (int y = 0; y < grid_h; y++)
        for (int x = 1; x < grid_w; x++)
          add_cell(cell_of(x, y, z), cell_of(x - 1, y, z));
    for (int z = 0; z < grid_p; z++)
      for (int x = 0; x < grid_w; x++)
        for (int y = 1; y < grid_h; y++)
          add_cell(cell_of(x, y, z), cell_of(x, y - 1, z));
  endfunction

  function automatic void apply_chunk_command(logic [1:0] cmd, int x, int y, int z,
                                              count_t b, count_t g, count_t r);
    sum_result_t res;
    int c;
    res.status = STATUS_OK;
    res.blue = '0;
    res.green = '0;
    res.red = '0;
    c = cell_of(x, y, z);
    if (cmd == cgsat_pkg::CMD_LOAD || cmd == cgsat_pkg::CMD_READ) begin
      if (x >= grid_w || y >= grid_h || z >= grid_p) begin
        res.status = STATUS_OUT_OF_GRID;
      end else if (cmd == cgsat_pkg::CMD_LOAD) begin
        blue_cells[c] = b;
        green_cells[c] = g;
        red_cells[c] = r;
        loaded_cells[c] = 1'b1;
      end else begin
        res.blue = blue_cells[c];
        res.green = green_cells[c];
        res.red = red_cells[c];
      end
    end else if (cmd == cgsat_pkg::CMD_COMPUTE) begin
      sum_planes();
    end
    expected_sums.insert(expected_sums.size(), res);
  endfunction

  function automatic bit grid_fully_loaded();
    for (int z = 0; z < grid_p; z++)
      for (int y = 0; y < grid_h; y++)
        for (int x = 0; x < grid_w; x++)
          if (!loaded_cells[cell_of(x, y, z)]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic count_t random_count();
    case ($urandom_range(9))
      0: return '0;
      1: return ALL_ONES;
      2: return ALL_ONES - count_t'($urandom_range(255));
      default: return count_t'({$urandom, $urandom});
    endcase
  endfunction

  task automatic send_item(logic [1:0] cmd, logic [3:0] x, logic [3:0] y, logic [1:0] z,
                           count_t b, count_t g, count_t r);
    if (!calm && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 37);
    end
    in_valid <= 1'b1;
    command <= cmd;
    chunk_x <= x;
    chunk_y <= y;
    chunk_z <= z;
    blue_in <= b;
    green_in <= g;
    red_in <= r;
    do @(posedge clk); while (in_stall);
    apply_chunk_command(cmd, int'(x), int'(y), int'(z), b, g, r);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_grid_reg(logic [cgsat_pkg::CFG_IDX_W-1:0] index,
                                logic [cgsat_pkg::CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (index)
      cgsat_pkg::REG_GRID_WIDTH:  grid_w = clamp_dim(int'(value), GRID_X);
      cgsat_pkg::REG_GRID_HEIGHT: grid_h = clamp_dim(int'(value), GRID_Y);
      cgsat_pkg::REG_GRID_PLANES: grid_p = clamp_dim(int'(value[2:0]), GRID_Z);
      default: ;
    endcase
  endtask

  task automatic set_grid(int w, int h, int p);
    write_grid_reg(cgsat_pkg::REG_GRID_WIDTH, cgsat_pkg::CFG_W'(w));
    write_grid_reg(cgsat_pkg::REG_GRID_HEIGHT, cgsat_pkg::CFG_W'(h));
    write_grid_reg(cgsat_pkg::REG_GRID_PLANES, cgsat_pkg::CFG_W'(p));
  endtask

  task automatic unused_item();
    send_item(CMD_UNUSED, 4'($urandom), 4'($urandom), 2'($urandom),
              random_count(), random_count(), random_count());
  endtask

  task automatic compute_item();
    int x, y, z;
    if (grid_fully_loaded()) begin
      send_item(cgsat_pkg::CMD_COMPUTE, 4'($urandom), 4'($urandom), 2'($urandom),
                random_count(), random_count(), random_count());
    end else begin
      x = $urandom_range(grid_w - 1);
      y = $urandom_range(grid_h - 1);
      z = $urandom_range(grid_p - 1);
      send_item(cgsat_pkg::CMD_LOAD, 4'(x), 4'(y), 2'(z),
                random_count(), random_count(), random_count());
    end
  endtask

  // reads only cells that hold data, otherwise loads them
  task automatic in_grid_item(bit want_read);
    int x, y, z;
    x = $urandom_range(grid_w - 1);
    y = $urandom_range(grid_h - 1);
    z = $urandom_range(grid_p - 1);
    send_item((want_read && loaded_cells[cell_of(x, y, z)]) ?
              cgsat_pkg::CMD_READ : cgsat_pkg::CMD_LOAD,
              4'(x), 4'(y), 2'(z), random_count(), random_count(), random_count());
  endtask

  task automatic out_of_grid_item();
    logic [3:0] x, y;
    logic [1:0] z;
    int dim;
    x = 4'($urandom);
    y = 4'($urandom);
    z = 2'($urandom);
    if (grid_w == GRID_X && grid_h == GRID_Y && grid_p == GRID_Z) begin
      unused_item();
    end else begin
      do dim = $urandom_range(2);
      while ((dim == 0 && grid_w == GRID_X) || (dim == 1 && grid_h == GRID_Y) ||
             (dim == 2 && grid_p == GRID_Z));
      case (dim)
        0: x = 4'($urandom_range(GRID_X - 1, grid_w));
        1: y = 4'($urandom_range(GRID_Y - 1, grid_h));
        default: z = 2'($urandom_range(GRID_Z - 1, grid_p));
      endcase
      send_item($urandom_range(1) ? cgsat_pkg::CMD_LOAD : cgsat_pkg::CMD_READ, x, y, z,
                random_count(), random_count(), random_count());
    end
  endtask

  task automatic mixed_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) in_grid_item(1'b1);
    else if (pick < 72) in_grid_item(1'b0);
    else if (pick < 88) out_of_grid_item();
    else unused_item();
  endtask

  // small grids: load every cell in random order; then mix reads, loads and computes
  task automatic run_grid_phase(int w, int h, int p, int mixed_items);
    int order [$];
    int j, tmp, computes;
    wait_idle();
    set_grid(w, h, p);
    if (grid_w * grid_h * grid_p <= SWEEP_LIMIT) begin
      for (int z = 0; z < grid_p; z++)
        for (int y = 0; y < grid_h; y++)
          for (int x = 0; x < grid_w; x++)
            order.insert(order.size(), cell_of(x, y, z));
      for (int i = order.size() - 1; i > 0; i--) begin
        j = $urandom_range(i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      foreach (order[i]) begin
        if ($urandom_range(99) < 15) begin
          if ($urandom_range(1)) out_of_grid_item();
          else unused_item();
        end
        send_item(cgsat_pkg::CMD_LOAD, 4'(order[i] % GRID_X),
                  4'((order[i] / GRID_X) % GRID_Y),
                  2'(order[i] / (GRID_X * GRID_Y)),
                  random_count(), random_count(), random_count());
      end
    end
    computes = 0;
    repeat (mixed_items) begin
      if (computes < 3 && $urandom_range(99) < 8) begin
        compute_item();
        computes++;
      end else begin
        mixed_item();
      end
    end
  endtask

  task automatic test_directed_commands();
    send_item(cgsat_pkg::CMD_READ, 4'd1, 4'd0, 2'd0, '0, '0, '0);
    send_item(cgsat_pkg::CMD_READ, 4'd0, 4'd15, 2'd3, ALL_ONES, ALL_ONES, ALL_ONES);
    send_item(cgsat_pkg::CMD_LOAD, 4'd0, 4'd0, 2'd0, ALL_ONES, '0, 48'h5a5a_a5a5_0f0f);
    send_item(cgsat_pkg::CMD_READ, 4'd0, 4'd0, 2'd0, '0, '0, '0);
    send_item(cgsat_pkg::CMD_LOAD, 4'd15, 4'd15, 2'd3, '0, '0, '0);
    send_item(cgsat_pkg::CMD_READ, 4'd0, 4'd0, 2'd0, '0, '0, '0);
    send_item(CMD_UNUSED, 4'd15, 4'd15, 2'd3, ALL_ONES, ALL_ONES, ALL_ONES);
    send_item(cgsat_pkg::CMD_COMPUTE, 4'd15, 4'd15, 2'd3, ALL_ONES, ALL_ONES, ALL_ONES);
    send_item(cgsat_pkg::CMD_COMPUTE, 4'd0, 4'd0, 2'd0, '0, '0, '0);
    send_item(cgsat_pkg::CMD_READ, 4'd0, 4'd0, 2'd0, '0, '0, '0);
  endtask

  task automatic test_register_clamp();
    wait_idle();
    write_grid_reg(cgsat_pkg::REG_GRID_WIDTH, 5'd0);
    write_grid_reg(cgsat_pkg::REG_GRID_HEIGHT, 5'd31);
    write_grid_reg(cgsat_pkg::REG_GRID_PLANES, 5'd0);
    send_item(cgsat_pkg::CMD_LOAD, 4'd0, 4'd15, 2'd0, ALL_ONES, 48'd1, 48'd2);
    send_item(cgsat_pkg::CMD_LOAD, 4'd1, 4'd0, 2'd0, ALL_ONES, ALL_ONES, ALL_ONES);
    send_item(cgsat_pkg::CMD_READ, 4'd0, 4'd0, 2'd1, '0, '0, '0);
    wait_idle();
    write_grid_reg(cgsat_pkg::REG_GRID_WIDTH, 5'd31);
    write_grid_reg(cgsat_pkg::REG_GRID_HEIGHT, 5'd2);
    write_grid_reg(cgsat_pkg::REG_GRID_PLANES, 5'd7);
    send_item(cgsat_pkg::CMD_LOAD, 4'd15, 4'd0, 2'd3, 48'd7, 48'd8, 48'd9);
    send_item(cgsat_pkg::CMD_LOAD, 4'd0, 4'd2, 2'd0, ALL_ONES, ALL_ONES, ALL_ONES);
    wait_idle();
    set_grid(2, 2, 1);
    // sums wrap past the top of the count range
    send_item(cgsat_pkg::CMD_LOAD, 4'd0, 4'd0, 2'd0, ALL_ONES, 48'd10, ALL_ONES - 48'd1);
    send_item(cgsat_pkg::CMD_LOAD, 4'd1, 4'd0, 2'd0, 48'd1, 48'd20, 48'd3);
    send_item(cgsat_pkg::CMD_LOAD, 4'd0, 4'd1, 2'd0, 48'd2, 48'd30, ALL_ONES);
    send_item(cgsat_pkg::CMD_LOAD, 4'd1, 4'd1, 2'd0, 48'd3, 48'd40, 48'd5);
    send_item(cgsat_pkg::CMD_COMPUTE, 4'd0, 4'd0, 2'd0, '0, '0, '0);
    send_item(cgsat_pkg::CMD_READ, 4'd1, 4'd0, 2'd0, '0, '0, '0);
    send_item(cgsat_pkg::CMD_READ, 4'd0, 4'd1, 2'd0, '0, '0, '0);
    send_item(cgsat_pkg::CMD_READ, 4'd1, 4'd1, 2'd0, '0, '0, '0);
  endtask

  // receiver holds off while the sender keeps offering transfers
  task automatic test_output_hold_off();
    wait_idle();
    hold_requests <= hold_requests + 1;
    calm = 1'b1;
    repeat (30) mixed_item();
    calm = 1'b0;
  endtask

  task automatic test_random_phases();
    int w, h, p;
    calm = 1'b1;
    run_grid_phase(16, 1, 1, 60);
    calm = 1'b0;
    run_grid_phase(0, 31, 7, 80);
    run_grid_phase(16, 16, 1, 80);
    run_grid_phase(16, 16, 4, 120);
    while (items_sent < TARGET_ITEMS) begin
      w = $urandom_range(6, 1);
      h = $urandom_range(6, 1);
      p = $urandom_range(3, 1);
      if ($urandom_range(9) == 0) w = 0;
      if ($urandom_range(9) == 0) p = 31;
      run_grid_phase(w, h, p, $urandom_range(90, 40));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_OFF_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 37);
    end
  end

  always @(posedge clk) begin
    sum_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: status %0d blue %h green %h red %h",
                   status, blue_sum, green_sum, red_sum);
      end else begin
        want = expected_sums.pop_front();
        if (status !== want.status || blue_sum !== want.blue ||
            green_sum !== want.green || red_sum !== want.red) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected status %0d blue %h green %h red %h",
                     want.status, want.blue, want.green, want.red);
            $display("          actual   status %0d blue %h green %h red %h",
                     status, blue_sum, green_sum, red_sum);
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = cgsat_pkg::REG_GRID_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    command = cgsat_pkg::CMD_LOAD;
    chunk_x = '0;
    chunk_y = '0;
    chunk_z = '0;
    blue_in = '0;
    green_in = '0;
    red_in = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_commands();
    test_register_clamp();
    test_output_hold_off();
    test_random_phases();
    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("chunk_grid_summed_area_table verification clean");
    end else begin
      $display("chunk_grid_summed_area_table verification failed");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("chunk_grid_summed_area_table verification failed");
    $finish;
  end

endmodule

### chunk_grid_summed_area_table.f
+incdir+design
design/cgsat_pkg.sv
design/cgsat_ram.sv
design/cgsat_lane.sv
design/cgsat_seq.sv
design/chunk_grid_summed_area_table.sv
sim/tb_chunk_grid_summed_area_table.sv
